### sv/co2_wahr_pkg.sv
`default_nettype none

package co2_wahr_pkg;

   localparam int VALUE_W     = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOWER_LIMIT = 1'b0,
      CSR_UPPER_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### sv/co2_wahr_ifs.sv
`default_nettype none

interface co2_wahr_req_if;
   import co2_wahr_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic [VALUE_W-1:0] sample_value;
   logic               manual_on;

   modport source (output valid, cmd, sample_value, manual_on, input ready);
   modport sink   (input valid, cmd, sample_value, manual_on, output ready);
endinterface

interface co2_wahr_rsp_if;
   import co2_wahr_pkg::*;

   logic               valid;
   logic               ready;
   logic               relay_active;
   logic               relay_changed;
   logic [VALUE_W-1:0] window_average;
   logic               sample_taken;

   modport source (output valid, relay_active, relay_changed, window_average, sample_taken,
                   input ready);
   modport sink   (input valid, relay_active, relay_changed, window_average, sample_taken,
                   output ready);
endinterface

`default_nettype wire

### sv/co2_wahr_divider.sv
`default_nettype none

module co2_wahr_divider #(
   parameter int DIVIDEND_W = 19,
   parameter int DIVISOR_W  = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);
   import co2_wahr_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [DIVIDEND_W-1:0] quo_ff;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;
   logic [DIVISOR_W-1:0]  rem_in;
   logic [DIVIDEND_W-1:0] quo_in;

   // one quotient bit per cycle, restoring form
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      fits      = (rem_shift >= {1'b0, div_ff});
      rem_in    = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      quo_in    = {quo_ff[DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### sv/co2_window_average_hysteresis_relay.sv
`default_nettype none

// Windowed gas-concentration average driving a relay with hysteresis.
// req_chan carries one item: a sample (cmd 0) or a manual relay set (cmd 1).
// rsp_chan returns exactly one item per request item: relay state, changed
// flag, window average and a sample-taken flag. csr_* writes the lower and
// upper limits; write them only while the block is idle.
// A nonzero sample is written into the ring memory on accept, then the ring
// is swept one entry per cycle through its registered read port, and the sum
// is divided by the count of filled entries in a bit-serial divider.
// A manual or zero-sample item goes straight to the finish state; a stored
// sample first passes through the ring sweep and the divider. Either way the
// result is then loaded into the registered rsp output.
// One item is worked on at a time; the next item is accepted once the result
// has moved into the output register, even while the receiver stalls it.
// Reset clears the limits, relay, write slot and per-entry valid bits, so the
// ring reads as empty; no clearing pass is needed.
module co2_window_average_hysteresis_relay #(
   parameter int WINDOW_LEN = 6
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   co2_wahr_req_if.sink                               req_chan,
   co2_wahr_rsp_if.source                             rsp_chan,
   input  wire logic                                  csr_we,
   input  wire logic [co2_wahr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [co2_wahr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import co2_wahr_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int SUM_W = VALUE_W + CNT_W;

   state_type state_ff, state_in;

   logic [VALUE_W-1:0]    lower_ff, upper_ff;
   logic                  relay_ff;
   logic [IDX_W-1:0]      slot_ff;
   logic [WINDOW_LEN-1:0] valid_ff;
   logic [VALUE_W-1:0]    window_mem [WINDOW_LEN];

   logic [CNT_W-1:0]      rd_idx_ff;
   logic                  rd_pend_ff;
   logic                  rd_hit_ff;
   logic [VALUE_W-1:0]    rd_data_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic                  cmd_ff, manual_ff, taken_ff;
   logic [VALUE_W-1:0]    avg_ff;

   logic                  rsp_valid_ff, rsp_relay_ff, rsp_changed_ff, rsp_taken_ff;
   logic [VALUE_W-1:0]    rsp_avg_ff;

   logic                  req_ready, req_acc, store;
   logic                  issue, sweep_done, div_start, div_done, rsp_load;
   logic [SUM_W-1:0]      div_quo;
   logic                  relay_in, changed_in;

   assign req_acc    = req_chan.valid && req_ready;
   assign store      = req_acc && !req_chan.cmd && (req_chan.sample_value != '0);
   assign issue      = (state_ff == ST_SUM) && (rd_idx_ff != CNT_W'(WINDOW_LEN));
   assign sweep_done = (rd_idx_ff == CNT_W'(WINDOW_LEN)) && !rd_pend_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_acc) state_in = store ? ST_SUM : ST_FINISH;
         ST_SUM:    if (sweep_done) state_in = ST_DIV;
         ST_DIV:    if (div_done) state_in = ST_FINISH;
         ST_FINISH: if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SUM:    div_start = sweep_done;
         ST_DIV:    ;
         ST_FINISH: rsp_load  = !rsp_valid_ff || rsp_chan.ready;
         default:   ;
      endcase
   end

   // hysteresis rule; the relay state decides which test can apply
   always_comb begin
      relay_in   = relay_ff;
      changed_in = 1'b0;
      if (cmd_ff) begin
         relay_in = manual_ff;
      end else if (taken_ff) begin
         if (avg_ff > upper_ff && !relay_ff) begin
            relay_in   = 1'b1;
            changed_in = 1'b1;
         end else if (avg_ff < lower_ff && relay_ff) begin
            relay_in   = 1'b0;
            changed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lower_ff     <= '0;
         upper_ff     <= '0;
         relay_ff     <= 1'b0;
         slot_ff      <= '0;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= issue;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_LOWER_LIMIT: lower_ff <= csr_wdata[VALUE_W-1:0];
               CSR_UPPER_LIMIT: upper_ff <= csr_wdata[VALUE_W-1:0];
               default:         ;
            endcase
         end
         if (store) begin
            valid_ff[slot_ff] <= 1'b1;
            slot_ff <= (slot_ff == IDX_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + IDX_W'(1);
         end
         if (rsp_load) begin
            relay_ff     <= relay_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         window_mem[slot_ff] <= req_chan.sample_value;
      end
      if (issue) begin
         rd_data_ff <= window_mem[rd_idx_ff[IDX_W-1:0]];
         rd_hit_ff  <= valid_ff[rd_idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff    <= req_chan.cmd;
         manual_ff <= req_chan.manual_on;
         taken_ff  <= store;
         avg_ff    <= '0;
         rd_idx_ff <= '0;
         sum_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         end
         // stored entries are nonzero, so a valid entry counts
         if (rd_pend_ff && rd_hit_ff) begin
            sum_ff <= sum_ff + SUM_W'(rd_data_ff);
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (div_done) begin
            avg_ff <= div_quo[VALUE_W-1:0];
         end
      end
      if (rsp_load) begin
         rsp_relay_ff   <= relay_in;
         rsp_changed_ff <= changed_in;
         rsp_avg_ff     <= avg_ff;
         rsp_taken_ff   <= taken_ff;
      end
   end

   co2_wahr_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.relay_active   = rsp_relay_ff;
   assign rsp_chan.relay_changed  = rsp_changed_ff;
   assign rsp_chan.window_average = rsp_avg_ff;
   assign rsp_chan.sample_taken   = rsp_taken_ff;

endmodule

`default_nettype wire

### sv/co2_wahr_checker.sv
`default_nettype none

module co2_wahr_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic                               rsp_relay_active,
   input wire logic                               rsp_relay_changed,
   input wire logic [co2_wahr_pkg::VALUE_W-1:0]   rsp_window_average,
   input wire logic                               rsp_sample_taken
);
   import co2_wahr_pkg::*;

   // stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_relay_active)
         && $stable(rsp_relay_changed) && $stable(rsp_window_average)
         && $stable(rsp_sample_taken))
      else $error("stalled rsp item changed");

   // only a stored sample can raise relay_changed or carry an average
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sample_taken |-> !rsp_relay_changed && rsp_window_average == '0)
      else $error("rsp item without sample shows change or average");

   // one item in flight: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while previous item in progress");

   // no result appears straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind co2_window_average_hysteresis_relay co2_wahr_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_relay_active   (rsp_chan.relay_active),
   .rsp_relay_changed  (rsp_chan.relay_changed),
   .rsp_window_average (rsp_chan.window_average),
   .rsp_sample_taken   (rsp_chan.sample_taken)
);

`default_nettype wire
